/* rtl/core/byte_stuffed_info_framer_top_defines.svh */
// assertion macros shared by the framer rtl
// no dependencies
`ifndef BYTE_STUFFED_INFO_FRAMER_TOP_DEFINES_SVH
`define BYTE_STUFFED_INFO_FRAMER_TOP_DEFINES_SVH

// clocked check, masked while reset is asserted
`define BSIF_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds during reset
`define BSIF_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/bsif_pkg.sv */
// shared types and constants of the byte stuffed information framer
// no dependencies
`default_nettype none

package bsif_pkg;

  localparam logic [7:0] TransparencyMask = 8'h20;

  localparam logic [7:0] FlagReset     = 8'h7E;
  localparam logic [7:0] EscapeReset   = 8'h7D;
  localparam logic [7:0] AddressReset  = 8'h03;
  localparam logic [7:0] CtrlZeroReset = 8'h00;
  localparam logic [7:0] CtrlOneReset  = 8'h40;

  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] escape_value;
    logic [7:0] address_value;
    logic [7:0] control_seq_zero;
    logic [7:0] control_seq_one;
  } cfg_t;

  // one classified payload beat
  typedef struct packed {
    logic [7:0] data;
    logic       open;
    logic       seq;
    logic       last;
    logic [7:0] bcc2;
  } job_t;

endpackage

`default_nettype wire

/* rtl/core/bsif_if.sv */
// valid/ready channel interfaces for framer input beats and line bytes
// no dependencies
`default_nettype none

interface bsif_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       seq_number;
  logic       last_byte;

  modport source (output valid, payload_byte, seq_number, last_byte, input ready);
  modport sink   (input valid, payload_byte, seq_number, last_byte, output ready);
endinterface

interface bsif_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       run_last;
  logic       frame_done;

  modport source (output valid, line_byte, run_last, frame_done, input ready);
  modport sink   (input valid, line_byte, run_last, frame_done, output ready);
endinterface

`default_nettype wire

/* rtl/core/byte_stuffed_info_framer_top.sv */
// Byte stuffed information framer. Each accepted payload beat yields its line bytes on
// the output channel, one byte per cycle unless out_ch.ready holds it back: the opening
// flag, address, control and bcc1 ahead of a frame's first beat, the (possibly escaped)
// payload byte, and bcc2 and the closing flag after a beat marked last. A beat therefore
// yields 1 to 12 line bytes; the back end's single byte output register sends them one at
// a time, while a two entry queue lets the front accept further beats meanwhile.
// Registers sit on an APB port at byte addresses 0, 4, 8, 12 and 16 and are to be
// written only while the block is idle.
`default_nettype none

module byte_stuffed_info_framer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  bsif_in_if.sink          in_ch,
  bsif_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [2:0] RegFlag  = 3'd0;
  localparam logic [2:0] RegEsc   = 3'd1;
  localparam logic [2:0] RegAddr  = 3'd2;
  localparam logic [2:0] RegCtrl0 = 3'd3;
  localparam logic [2:0] RegCtrl1 = 3'd4;

  bsif_pkg::cfg_t cfg_q, cfg_d;
  bsif_pkg::job_t push_job, head;
  logic           push, full, empty, pop, wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegFlag:  cfg_d.flag_value       = pwdata[7:0];
        RegEsc:   cfg_d.escape_value     = pwdata[7:0];
        RegAddr:  cfg_d.address_value    = pwdata[7:0];
        RegCtrl0: cfg_d.control_seq_zero = pwdata[7:0];
        RegCtrl1: cfg_d.control_seq_one  = pwdata[7:0];
        default:  cfg_d = cfg_q;
      endcase
    end
    case (reg_idx)
      RegFlag:  prdata = {24'h0, cfg_q.flag_value};
      RegEsc:   prdata = {24'h0, cfg_q.escape_value};
      RegAddr:  prdata = {24'h0, cfg_q.address_value};
      RegCtrl0: prdata = {24'h0, cfg_q.control_seq_zero};
      RegCtrl1: prdata = {24'h0, cfg_q.control_seq_one};
      default:  prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_value       <= bsif_pkg::FlagReset;
      cfg_q.escape_value     <= bsif_pkg::EscapeReset;
      cfg_q.address_value    <= bsif_pkg::AddressReset;
      cfg_q.control_seq_zero <= bsif_pkg::CtrlZeroReset;
      cfg_q.control_seq_one  <= bsif_pkg::CtrlOneReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bsif_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .q_full_i   (full),
    .push_job_o (push_job),
    .push_o     (push)
  );

  bsif_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  bsif_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

/* rtl/core/bsif_front.sv */
// front end: accepts payload beats, tracks frame state and running bcc2
// depends on bsif_pkg, bsif_if, byte_stuffed_info_framer_top_defines.svh
`default_nettype none
`include "byte_stuffed_info_framer_top_defines.svh"

module bsif_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  bsif_in_if.sink            in_ch,
  input  wire logic          q_full_i,
  output bsif_pkg::job_t     push_job_o,
  output logic               push_o
);

  logic       in_frame_q, in_frame_d;
  logic [7:0] run_q, run_d;
  logic [7:0] chk;

  assign in_ch.ready = !q_full_i;
  assign push_o      = in_ch.valid && !q_full_i;

  always_comb begin
    chk = (in_frame_q ? run_q : 8'h00) ^ in_ch.payload_byte;
    push_job_o.data = in_ch.payload_byte;
    push_job_o.open = !in_frame_q;
    push_job_o.seq  = in_ch.seq_number;
    push_job_o.last = in_ch.last_byte;
    push_job_o.bcc2 = chk;
    in_frame_d = in_frame_q;
    run_d      = run_q;
    if (push_o) begin
      in_frame_d = !in_ch.last_byte;
      run_d      = in_ch.last_byte ? 8'h00 : chk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      run_q      <= 8'h00;
    end else begin
      in_frame_q <= in_frame_d;
      run_q      <= run_d;
    end
  end

  `BSIF_ASSERT(a_frame_closes, clk_i, rst_ni, (push_o && in_ch.last_byte) |=> !in_frame_q, "frame still open after last beat")

endmodule

`default_nettype wire

/* rtl/core/bsif_queue.sv */
// two entry queue of classified beats between front and back
// depends on bsif_pkg, byte_stuffed_info_framer_top_defines.svh
`default_nettype none
`include "byte_stuffed_info_framer_top_defines.svh"

module bsif_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bsif_pkg::job_t push_job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output bsif_pkg::job_t      head_o
);

  bsif_pkg::job_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  `BSIF_ASSERT(a_no_overflow, clk_i, rst_ni, (cnt_q != 2'd3) && !(push_i && full_o) && !(pop_i && empty_o), "queue over or underflow")

endmodule

`default_nettype wire

/* rtl/core/bsif_back.sv */
// back end: walks header, payload and trailer of the head beat with byte stuffing
// depends on bsif_pkg, bsif_if, byte_stuffed_info_framer_top_defines.svh
`default_nettype none
`include "byte_stuffed_info_framer_top_defines.svh"

module bsif_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bsif_pkg::cfg_t cfg_i,
  input  wire logic           empty_i,
  input  wire bsif_pkg::job_t head_i,
  output logic                pop_o,
  bsif_out_if.source          out_ch
);

  localparam logic [2:0] StOpen  = 3'd0;
  localparam logic [2:0] StAddr  = 3'd1;
  localparam logic [2:0] StCtrl  = 3'd2;
  localparam logic [2:0] StBcc1  = 3'd3;
  localparam logic [2:0] StData  = 3'd4;
  localparam logic [2:0] StBcc2  = 3'd5;
  localparam logic [2:0] StClose = 3'd6;

  logic [2:0] step_q, step_d, cur_step, nxt_step;
  logic       started_q, started_d;
  logic       esc_q, esc_d;
  logic       ovalid_q, ovalid_d;
  logic [7:0] obyte_q, obyte_d;
  logic       olast_q, olast_d;
  logic       odone_q, odone_d;
  logic       emit, job_end, advance, stuffable, match;
  logic [7:0] ctrl, cur_byte;

  always_comb begin
    emit     = !empty_i && (!ovalid_q || out_ch.ready);
    cur_step = started_q ? step_q : (head_i.open ? StOpen : StData);
    ctrl     = head_i.seq ? cfg_i.control_seq_one : cfg_i.control_seq_zero;

    stuffable = 1'b1;
    nxt_step  = StData;
    job_end   = 1'b0;
    case (cur_step)
      StOpen: begin
        cur_byte  = cfg_i.flag_value;
        stuffable = 1'b0;
        nxt_step  = StAddr;
      end
      StAddr: begin
        cur_byte = cfg_i.address_value;
        nxt_step = StCtrl;
      end
      StCtrl: begin
        cur_byte = ctrl;
        nxt_step = StBcc1;
      end
      StBcc1: begin
        cur_byte = cfg_i.address_value ^ ctrl;
        nxt_step = StData;
      end
      StData: begin
        cur_byte = head_i.data;
        nxt_step = StBcc2;
        job_end  = !head_i.last;
      end
      StBcc2: begin
        cur_byte = head_i.bcc2;
        nxt_step = StClose;
      end
      StClose: begin
        cur_byte  = cfg_i.flag_value;
        stuffable = 1'b0;
        job_end   = 1'b1;
      end
      default: begin
        cur_byte  = cfg_i.flag_value;
        stuffable = 1'b0;
        job_end   = 1'b1;
      end
    endcase

    match = stuffable &&
            (cur_byte == cfg_i.flag_value || cur_byte == cfg_i.escape_value);

    if (esc_q) begin
      obyte_d = cur_byte ^ bsif_pkg::TransparencyMask;
      advance = 1'b1;
    end else if (match) begin
      obyte_d = cfg_i.escape_value;
      advance = 1'b0;
    end else begin
      obyte_d = cur_byte;
      advance = 1'b1;
    end

    olast_d = advance && job_end;
    odone_d = cur_step == StClose;
    pop_o   = emit && advance && job_end;

    step_d    = step_q;
    started_d = started_q;
    esc_d     = esc_q;
    if (emit) begin
      if (pop_o) begin
        started_d = 1'b0;
        esc_d     = 1'b0;
      end else begin
        started_d = 1'b1;
        esc_d     = !advance;
        step_d    = advance ? nxt_step : cur_step;
      end
    end

    if (emit) begin
      ovalid_d = 1'b1;
    end else if (out_ch.ready) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= StOpen;
      started_q <= 1'b0;
      esc_q     <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      step_q    <= step_d;
      started_q <= started_d;
      esc_q     <= esc_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      obyte_q <= obyte_d;
      olast_q <= olast_d;
      odone_q <= odone_d;
    end
  end

  assign out_ch.valid      = ovalid_q;
  assign out_ch.line_byte  = obyte_q;
  assign out_ch.run_last   = olast_q;
  assign out_ch.frame_done = odone_q;

  `BSIF_ASSERT(a_done_is_last, clk_i, rst_ni, (ovalid_q && odone_q) |-> olast_q, "closing flag not marked last")
  `BSIF_ASSERT_ALWAYS(a_esc_in_job, clk_i, esc_q |-> started_q, "escape pending outside a beat")

endmodule

`default_nettype wire

/* tb/bsif_tb_pkg.sv */
// register indexes of the framer config port, shared by the bench and its checker
// depends on nothing
package bsif_tb_pkg;

  typedef enum logic [2:0] {
    RegFlag,
    RegEscape,
    RegAddress,
    RegCtrlZero,
    RegCtrlOne,
    RegSpare
  } reg_idx_e;

endpackage

/* tb/bsif_frame_checker.sv */
// checker for the framer: follows config writes, predicts the stuffed line bytes
// of every accepted payload beat and compares them with the output channel
// depends on bsif_pkg, bsif_tb_pkg and the channel interfaces
module bsif_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsif_in_if          in_ch,
  bsif_out_if         out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import bsif_pkg::*;
  import bsif_tb_pkg::*;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_done;
  } line_beat_t;

  cfg_t       cfg;
  logic       frame_open;
  logic [7:0] payload_xor;
  logic [8:0] burst[$];
  line_beat_t line_bytes_due[$];
  int         mismatches = 0;

  function automatic void add_stuffed(logic [7:0] b);
    if (b == cfg.flag_value || b == cfg.escape_value) begin
      burst.push_back({1'b0, cfg.escape_value});
      burst.push_back({1'b0, b ^ TransparencyMask});
    end else begin
      burst.push_back({1'b0, b});
    end
  endfunction

  function automatic void frame_payload_beat(logic [7:0] data, logic seq, logic last);
    logic [7:0] ctrl;
    line_beat_t lb;
    burst.delete();
    if (!frame_open) begin
      ctrl = seq ? cfg.control_seq_one : cfg.control_seq_zero;
      burst.push_back({1'b0, cfg.flag_value});
      add_stuffed(cfg.address_value);
      add_stuffed(ctrl);
      add_stuffed(cfg.address_value ^ ctrl);
      frame_open  = 1'b1;
      payload_xor = 8'h00;
    end
    add_stuffed(data);
    payload_xor ^= data;
    if (last) begin
      add_stuffed(payload_xor);
      burst.push_back({1'b1, cfg.flag_value});
      frame_open  = 1'b0;
      payload_xor = 8'h00;
    end
    foreach (burst[i]) begin
      lb.line_byte  = burst[i][7:0];
      lb.frame_done = burst[i][8];
      lb.run_last   = (i == burst.size() - 1);
      line_bytes_due.push_back(lb);
    end
  endfunction

  function automatic void note_failure(string what, line_beat_t want, line_beat_t seen);
    if (mismatches < 10) begin
      $display("%t %s: expected byte %h last %b done %b, got byte %h last %b done %b",
               $realtime, what, want.line_byte, want.run_last, want.frame_done,
               seen.line_byte, seen.run_last, seen.frame_done);
    end
    mismatches++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    line_beat_t seen;
    line_beat_t want;
    if (!rst_ni) begin
      cfg.flag_value       = FlagReset;
      cfg.escape_value     = EscapeReset;
      cfg.address_value    = AddressReset;
      cfg.control_seq_zero = CtrlZeroReset;
      cfg.control_seq_one  = CtrlOneReset;
      frame_open           = 1'b0;
      payload_xor          = 8'h00;
      line_bytes_due.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegFlag:     cfg.flag_value       = pwdata[7:0];
          RegEscape:   cfg.escape_value     = pwdata[7:0];
          RegAddress:  cfg.address_value    = pwdata[7:0];
          RegCtrlZero: cfg.control_seq_zero = pwdata[7:0];
          RegCtrlOne:  cfg.control_seq_one  = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.line_byte  = out_ch.line_byte;
        seen.run_last   = out_ch.run_last;
        seen.frame_done = out_ch.frame_done;
        if (line_bytes_due.size() == 0) begin
          note_failure("line byte with none due", '0, seen);
        end else begin
          want = line_bytes_due.pop_front();
          if (seen.line_byte !== want.line_byte || seen.run_last !== want.run_last ||
              seen.frame_done !== want.frame_done) begin
            note_failure("line byte mismatch", want, seen);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        frame_payload_beat(in_ch.payload_byte, in_ch.seq_number, in_ch.last_byte);
      end
      pending_o    <= line_bytes_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

/* tb/tb.sv */
// bench top for the framer: clock, reset, config writes over apb, payload beats and
// line-side backpressure; the checker beside the block predicts and compares
// depends on bsif_pkg, bsif_tb_pkg, the channel interfaces and bsif_frame_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsif_pkg::*;
  import bsif_tb_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  bit          quiet;
  bit          hold_request;
  int          stall_left;
  int          phase_beats;
  logic [7:0]  cur_flag;
  logic [7:0]  cur_escape;

  bsif_in_if  in_ch ();
  bsif_out_if out_ch ();

  byte_stuffed_info_framer_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bsif_frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // line side backpressure
  initial begin
    stall_left   = 0;
    out_ch.ready <= 1'b0;
    forever @(posedge clk_i) begin
      int r;
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = 200;
        out_ch.ready <= 1'b0;
      end else if (quiet || r < 75) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left   = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 25);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return cur_flag;
    if (r < 35) return cur_escape;
    if (r < 40) return 8'h00;
    if (r < 45) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic apb_write(reg_idx_e idx, logic [7:0] value);
    logic [23:0] upper;
    upper   = 24'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {upper, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (idx == RegFlag) cur_flag = value;
    if (idx == RegEscape) cur_escape = value;
  endtask

  task automatic set_config(logic [7:0] f, logic [7:0] e, logic [7:0] a,
                            logic [7:0] c0, logic [7:0] c1);
    apb_write(RegFlag, f);
    apb_write(RegEscape, e);
    apb_write(RegAddress, a);
    apb_write(RegCtrlZero, c0);
    apb_write(RegCtrlOne, c1);
  endtask

  task automatic send_beat(logic [7:0] data, logic seq, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.payload_byte <= data;
    in_ch.seq_number   <= seq;
    in_ch.last_byte    <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    phase_beats++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_frame();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = (r < 70) ? $urandom_range(1, 4) : (r < 95) ? $urandom_range(5, 12) :
        $urandom_range(13, 30);
    for (int i = 0; i < n; i++) begin
      send_beat(pick_byte(), 1'($urandom), i == n - 1);
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.payload_byte <= '0;
    in_ch.seq_number   <= 1'b0;
    in_ch.last_byte    <= 1'b0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    phase_beats  = 0;
    cur_flag     = FlagReset;
    cur_escape   = EscapeReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: single byte frames, flag in payload and checksum
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h7E, 1'b1, 1'b1);
    // seq toggles mid-frame and must be ignored
    send_beat(8'h7D, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h5E, 1'b0, 1'b0);
    send_beat(8'h20, 1'b1, 1'b1);
    drain();

    // every header byte escaped: longest burst
    set_config(8'h00, 8'h7E, 8'h7E, 8'h7E, 8'hFF);
    send_beat(8'h7E, 1'b0, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'h7E, 1'b1, 1'b0);
    drain();
    // register change with a frame open, plus a write to an unused address
    apb_write(RegFlag, 8'h7E);
    apb_write(RegSpare, 8'h55);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h7E, 1'b0, 1'b1);
    drain();

    // flag equal to escape
    set_config(8'h7E, 8'h7E, 8'h7E, 8'h01, 8'h80);
    send_beat(8'h7E, 1'b0, 1'b1);
    send_beat(8'h01, 1'b1, 1'b0);
    send_beat(8'hFE, 1'b0, 1'b1);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(FlagReset, EscapeReset, AddressReset, CtrlZeroReset, CtrlOneReset);
        1: set_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        2: set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        5: set_config(FlagReset, EscapeReset, AddressReset, CtrlZeroReset, CtrlOneReset);
        default: set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom));
      endcase
      quiet       = (phase == 3);
      phase_beats = 0;
      if (phase == 1) hold_request = 1'b1;
      while (phase_beats < 36) begin
        send_frame();
        // sender pause until the line side has caught up
        if (phase == 2 && phase_beats >= 20 && phase_beats < 24) drain();
      end
      drain();
    end
    quiet = 1'b0;

    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
